// ===== sv/indexed_image_rle_decoder_core_macros.svh =====
// Assertion macros shared by the indexed image run-length decoder modules.
`ifndef INDEXED_IMAGE_RLE_DECODER_CORE_MACROS_SVH
`define INDEXED_IMAGE_RLE_DECODER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a property at every rising clock edge outside reset.
`define IIRLE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define IIRLE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define IIRLE_ASSERT(lbl, clk, rstn, prop, msg)
`define IIRLE_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== sv/iirle_pkg.sv =====
// Shared types and constants of the indexed image run-length decoder.
package iirle_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int DIM_W          = 13;
  localparam int CFG_IDX_W      = 2;
  localparam int CNT_W          = 7;
  localparam int MAX_RESULTS    = 64;

  localparam logic [7:0] RUN_BASE  = 8'd192;
  localparam logic [7:0] SKIP_BASE = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_CTRL   = 2'd0,
    PH_RUNVAL = 2'd1,
    PH_LIT    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_RUN   = 2'd2
  } kind_t;

  typedef struct packed {
    logic take;
    logic step;
  } iirle_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  run_last;
    logic  out_free;
    logic  rem_nz;
  } iirle_sts_t;

endpackage

// ===== sv/indexed_image_rle_decoder_core.sv =====
// Top level of the indexed image run-length decoder.
//
// Compressed bytes enter on the in_ channel, one item per byte, with in_frame_start
// marking the first byte of a frame. Decoded pixels leave on the out_ channel in raster
// order with their column and row, one item per pixel. Both channels move an item at a
// clock edge where valid is high and stall is low.
// A literal pixel is presented on out_ in the cycle after its byte is accepted.
// Literal bytes and plain bytes of copy mode are accepted without holding the input, as
// are control bytes that give no pixel. A run value or a skip byte of N pixels holds the
// input while the sequencer places one pixel per cycle unless the receiver stalls, from
// the EMIT state, so a run starts later than a literal; N is loaded into the run counter.
// Write configuration through cfg_ while no item is in flight; the block does not check.
// After reset the mode is copy runs, the image is one pixel, and the parser waits for
// a control byte. When the receiver stalls, the held pixel stays and the block stops
// accepting bytes until it is taken.
module indexed_image_rle_decoder_core import iirle_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]      cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_frame_start,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_pixel_value,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_last_of_item,
  output logic                  out_image_done
);

  iirle_cmd_t cmd;
  iirle_sts_t sts;

  iirle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  iirle_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .in_data_byte     (in_data_byte),
    .in_frame_start   (in_frame_start),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_pixel_value  (out_pixel_value),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_last_of_item (out_last_of_item),
    .out_image_done   (out_image_done),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

// ===== sv/iirle_datapath.sv =====
// Datapath: byte parser, position counters, run counter and result register.
`include "indexed_image_rle_decoder_core_macros.svh"

module iirle_datapath import iirle_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]      cfg_wr_data,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_frame_start,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [7:0]            out_pixel_value,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_last_of_item,
  output logic                  out_image_done,
  input  iirle_cmd_t            cmd,
  output iirle_sts_t            sts
);

  localparam int LIM_W = COORD_BITS + 1;
  localparam int CMP_W = (DIM_W > LIM_W) ? DIM_W : LIM_W;
  localparam logic [CMP_W-1:0] DIM_MAX = {{(CMP_W-1){1'b0}}, 1'b1} << COORD_BITS;

  function automatic logic [LIM_W-1:0] dim_limit(input logic [DIM_W-1:0] v);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (v == '0) begin
      dim_limit = LIM_W'(1);
    end else if (ve > DIM_MAX) begin
      dim_limit = LIM_W'(DIM_MAX);
    end else begin
      dim_limit = LIM_W'(ve);
    end
  endfunction

  logic                  mode_r;
  logic [LIM_W-1:0]      w_lim_r;
  logic [LIM_W-1:0]      h_lim_r;
  phase_t                phase_r, phase_nxt;
  logic [7:0]            lit_r, lit_nxt;
  logic [5:0]            pend_r, pend_nxt;
  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic                  fin_r, fin_nxt;
  logic [7:0]            val_r;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]      total_r, total_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic                  out_valid_r;

  phase_t                phase_e;
  logic [7:0]            lit_e;
  logic [5:0]            pend_e;
  logic [COORD_BITS-1:0] col_e, row_e;
  logic                  fin_e;

  logic [COORD_BITS-1:0] pos_col, pos_row;
  logic [LIM_W-1:0]      col_inc, row_inc;
  logic                  wrap;
  logic [COORD_BITS-1:0] col_new, row_new;
  logic                  fin_new;

  kind_t                 kind;
  logic [7:0]            run_val;
  logic [CNT_W-1:0]      run_cnt;
  logic [CNT_W-1:0]      skip_cnt;
  logic [LIM_W-1:0]      room;
  logic                  want;
  logic                  out_free;
  logic                  out_load;

  // A frame start clears position and parser before the byte is decoded.
  assign phase_e = in_frame_start ? PH_CTRL : phase_r;
  assign lit_e   = in_frame_start ? 8'd0 : lit_r;
  assign pend_e  = in_frame_start ? 6'd0 : pend_r;
  assign col_e   = in_frame_start ? '0 : col_r;
  assign row_e   = in_frame_start ? '0 : row_r;
  assign fin_e   = in_frame_start ? 1'b0 : fin_r;

  // One placement unit serves both a directly decoded pixel and each run pixel.
  assign pos_col = cmd.step ? col_r : col_e;
  assign pos_row = cmd.step ? row_r : row_e;
  assign col_inc = {1'b0, pos_col} + LIM_W'(1);
  assign wrap    = col_inc >= w_lim_r;
  assign col_new = wrap ? '0 : col_inc[COORD_BITS-1:0];
  assign row_inc = {1'b0, pos_row} + (wrap ? LIM_W'(1) : LIM_W'(0));
  assign row_new = row_inc[COORD_BITS-1:0];
  assign fin_new = row_inc >= h_lim_r;

  assign skip_cnt = in_data_byte[CNT_W-1:0];
  assign room     = (w_lim_r > {1'b0, col_e}) ? (w_lim_r - {1'b0, col_e}) : LIM_W'(1);

  always_comb begin
    kind      = KIND_NONE;
    run_val   = 8'd0;
    run_cnt   = '0;
    phase_nxt = phase_e;
    lit_nxt   = lit_e;
    pend_nxt  = pend_e;
    if (!fin_e) begin
      unique case (phase_e)
        PH_RUNVAL: begin
          run_val   = in_data_byte;
          run_cnt   = CNT_W'(pend_e);
          pend_nxt  = 6'd0;
          phase_nxt = PH_CTRL;
          kind      = (pend_e != 6'd0) ? KIND_RUN : KIND_NONE;
        end
        PH_LIT: begin
          kind    = KIND_PIXEL;
          lit_nxt = (lit_e != 8'd0) ? (lit_e - 8'd1) : 8'd0;
          if (lit_nxt == 8'd0) begin
            phase_nxt = PH_CTRL;
          end
        end
        default: begin
          if (!mode_r) begin
            if (in_data_byte > RUN_BASE) begin
              pend_nxt  = 6'(in_data_byte - RUN_BASE);
              phase_nxt = PH_RUNVAL;
            end else begin
              kind = KIND_PIXEL;
            end
          end else begin
            if (in_data_byte > SKIP_BASE) begin
              kind    = KIND_RUN;
              run_cnt = (LIM_W'(skip_cnt) > room) ? room[CNT_W-1:0] : skip_cnt;
            end else if (in_data_byte != 8'd0) begin
              lit_nxt   = in_data_byte;
              phase_nxt = PH_LIT;
            end
          end
        end
      endcase
    end
  end

  // Runs longer than the result bound report only their head and their final pixel.
  assign want = (total_r <= CNT_W'(MAX_RESULTS)) || (idx_r < CNT_W'(MAX_RESULTS - 1)) ||
                (rem_r == CNT_W'(1));

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (cmd.take && (kind == KIND_PIXEL)) || (cmd.step && (want || fin_new));

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    fin_nxt   = fin_r;
    rem_nxt   = rem_r;
    total_nxt = total_r;
    idx_nxt   = idx_r;
    if (cmd.take) begin
      if (kind == KIND_PIXEL) begin
        col_nxt = col_new;
        row_nxt = row_new;
        fin_nxt = fin_new;
      end else begin
        col_nxt = col_e;
        row_nxt = row_e;
        fin_nxt = fin_e;
      end
      if (kind == KIND_RUN) begin
        rem_nxt   = run_cnt;
        total_nxt = run_cnt;
        idx_nxt   = '0;
      end
    end else if (cmd.step) begin
      col_nxt = col_new;
      row_nxt = row_new;
      fin_nxt = fin_new;
      rem_nxt = rem_r - CNT_W'(1);
      idx_nxt = idx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      w_lim_r <= LIM_W'(1);
      h_lim_r <= LIM_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:   mode_r  <= cfg_wr_data[0];
        CFG_WIDTH:  w_lim_r <= dim_limit(cfg_wr_data);
        CFG_HEIGHT: h_lim_r <= dim_limit(cfg_wr_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CTRL;
      lit_r       <= 8'd0;
      pend_r      <= 6'd0;
      col_r       <= '0;
      row_r       <= '0;
      fin_r       <= 1'b0;
      rem_r       <= '0;
      total_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.take) begin
        phase_r <= phase_nxt;
        lit_r   <= lit_nxt;
        pend_r  <= pend_nxt;
      end
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      fin_r   <= fin_nxt;
      rem_r   <= rem_nxt;
      total_r <= total_nxt;
      idx_r   <= idx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && (kind == KIND_RUN)) begin
      val_r <= run_val;
    end
    if (out_load) begin
      out_pixel_value  <= cmd.step ? val_r : in_data_byte;
      out_pixel_x      <= pos_col;
      out_pixel_y      <= pos_row;
      out_last_of_item <= cmd.take || (rem_r == CNT_W'(1)) || fin_new;
      out_image_done   <= fin_new;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.kind     = kind;
  assign sts.run_last = (rem_r == CNT_W'(1)) || fin_new;
  assign sts.out_free = out_free;
  assign sts.rem_nz   = rem_r != '0;

  `IIRLE_ASSERT(a_quiet_when_done, clk, rst_n, fin_r && !(cmd.take && in_frame_start) |-> !out_load, "Pixel produced after the image was complete.")
  `IIRLE_ASSERT(a_done_is_last, clk, rst_n, out_valid_r && out_image_done |-> out_last_of_item, "Completing pixel is not marked as last of its item.")
  `IIRLE_ASSERT(a_run_count_steps, clk, rst_n, cmd.step |=> rem_r == $past(rem_r) - CNT_W'(1), "Run counter did not step down by one.")

endmodule

// ===== sv/iirle_ctrl.sv =====
// Controller: accepts input items and sequences the pixels of runs and skips.
`include "indexed_image_rle_decoder_core_macros.svh"

module iirle_ctrl import iirle_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  iirle_sts_t sts,
  output iirle_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = !((state_r == ST_IDLE) && sts.out_free);
  assign cmd.take = in_valid && !in_stall;
  assign cmd.step = (state_r == ST_EMIT) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.take && (sts.kind == KIND_RUN)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cmd.step && sts.run_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `IIRLE_ASSERT(a_emit_has_pixels, clk, rst_n, state_r == ST_EMIT |-> sts.rem_nz, "Emitting a run with no pixels left.")

endmodule
